FILE: design/pdh_pkg.sv
// ----------------------------------------------------------------------------
// pdh_pkg
// Shared types, codes and defaults of the pair distance histogram core.
// ----------------------------------------------------------------------------
package pdh_pkg;

   // Default sizes, handed to the top level as parameter defaults
   localparam int DEF_HIST_SETS  = 4;
   localparam int DEF_MAX_BINS   = 256;
   localparam int DEF_ATOM_TYPES = 4;
   localparam int DEF_COORD_BITS = 24;

   // Fixed field widths
   localparam int OP_W        = 2;
   localparam int TYPE_W      = 2;
   localparam int CLASS_W     = 2;
   localparam int SET_SEL_W   = 2;
   localparam int BIN_SEL_W   = 8;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // Configuration register widths
   localparam int BINS_W   = 9;
   localparam int INV_W    = 24;
   localparam int MAP_W    = 64;
   localparam int KEEP_W   = 4;
   localparam int NIBBLE_W = 4;

   // Q.12 radius times Q8.16 scale gives Q.28 bins
   localparam int BIN_FRAC_SHIFT = 28;

   // Configuration reset values
   localparam logic [BINS_W-1:0] RST_RADIAL_BINS   = 9'd256;
   localparam logic [INV_W-1:0]  RST_INV_BIN_WIDTH = 24'd65536;
   localparam logic [MAP_W-1:0]  RST_PAIR_SET_MAP  = 64'h1111_1111_1111_1111;
   localparam logic [KEEP_W-1:0] RST_SPECIAL_KEEP  = 4'hF;
   localparam logic              RST_REV_ALWAYS    = 1'b1;

   // Request operations
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_TALLY = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_TALLIED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FILTERED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BEYOND   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIAL_BINS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_BIN_WIDTH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAIR_SET_MAP  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPECIAL_KEEP  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REV_ALWAYS    = 3'd4;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_PICK,
      ST_SQUARE,
      ST_ROOT,
      ST_SCALE,
      ST_CHECK,
      ST_UPDATE,
      ST_DELIVER
   } pdh_state_type;

endpackage

FILE: design/pair_distance_histogram_core.sv
// ----------------------------------------------------------------------------
// pair_distance_histogram_core
// Radial pair distance histogram: filters neighbour pairs, bins their
// distance and bumps saturating counters held in one row-per-bin memory.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                  carries
//  req      in         req_valid / req_ready      one request (clear, tally, read)
//  rsp      out        rsp_valid / rsp_ready      status and count per request
//  csr      in         csr_wr_en                  register write, index and data
//
// A tally squares three axes through one shared multiplier, takes one root
// bit per cycle for the COORD_BITS + 1 root bits, does the scale multiply,
// then one read-modify-write of the bin row. A filtered or unused request
// goes straight to delivery, a read fetches the row and picks its counter,
// and a clear zeroes one memory row per cycle.
// After reset a clearing pass over all MAX_BINS rows runs before the first
// request is taken; configuration writes are taken throughout.
// The response sits in its own register, so a new request is taken while
// a finished response still waits on rsp_ready.
//
module pair_distance_histogram_core #(
   parameter int HIST_SETS  = pdh_pkg::DEF_HIST_SETS,
   parameter int MAX_BINS   = pdh_pkg::DEF_MAX_BINS,
   parameter int ATOM_TYPES = pdh_pkg::DEF_ATOM_TYPES,
   parameter int COORD_BITS = pdh_pkg::DEF_COORD_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pdh_pkg::OP_W-1:0]             req_op,
   input  logic signed [COORD_BITS-1:0]         req_dx,
   input  logic signed [COORD_BITS-1:0]         req_dy,
   input  logic signed [COORD_BITS-1:0]         req_dz,
   input  logic [pdh_pkg::TYPE_W-1:0]           req_first_type,
   input  logic [pdh_pkg::TYPE_W-1:0]           req_second_type,
   input  logic [pdh_pkg::CLASS_W-1:0]          req_special_class,
   input  logic                                 req_second_in_group,
   input  logic                                 req_second_is_local,
   input  logic [pdh_pkg::SET_SEL_W-1:0]        req_set_index,
   input  logic [pdh_pkg::BIN_SEL_W-1:0]        req_bin_index,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [pdh_pkg::STATUS_W-1:0]         rsp_status,
   output logic [pdh_pkg::COUNT_W-1:0]          rsp_count,

   input  logic                                 csr_wr_en,
   input  logic [pdh_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pdh_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // -------------------------------------------------------------------------
   // Derived sizes
   // -------------------------------------------------------------------------
   localparam int COUNT_W    = pdh_pkg::COUNT_W;
   localparam int ROW_W      = HIST_SETS * COUNT_W;
   localparam int BIN_W      = $clog2(MAX_BINS);
   localparam int BIN_EXT_W  = (BIN_W > pdh_pkg::BIN_SEL_W) ? BIN_W : pdh_pkg::BIN_SEL_W;
   localparam int SQ_W       = 2 * COORD_BITS;           // one square
   localparam int SUM_W      = 2 * COORD_BITS + 2;       // sum of three squares
   localparam int ROOT_W     = SUM_W / 2;                // integer root bits
   localparam int REM_W      = ROOT_W + 2;               // root remainder
   localparam int ROOT_CNT_W = $clog2(ROOT_W);
   localparam int PROD_W     = ROOT_W + pdh_pkg::INV_W;  // scaled radius
   localparam int SHIFT      = pdh_pkg::BIN_FRAC_SHIFT;

   localparam logic [BIN_W-1:0]      LAST_BIN  = BIN_W'(MAX_BINS - 1);
   localparam logic [ROOT_CNT_W-1:0] ROOT_LAST = ROOT_CNT_W'(ROOT_W - 1);

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic [pdh_pkg::BINS_W-1:0] radial_bins_ff;
   logic [pdh_pkg::INV_W-1:0]  inv_bin_width_ff;
   logic [pdh_pkg::MAP_W-1:0]  pair_set_map_ff;
   logic [pdh_pkg::KEEP_W-1:0] special_keep_ff;
   logic                       rev_always_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radial_bins_ff   <= pdh_pkg::RST_RADIAL_BINS;
         inv_bin_width_ff <= pdh_pkg::RST_INV_BIN_WIDTH;
         pair_set_map_ff  <= pdh_pkg::RST_PAIR_SET_MAP;
         special_keep_ff  <= pdh_pkg::RST_SPECIAL_KEEP;
         rev_always_ff    <= pdh_pkg::RST_REV_ALWAYS;
      end else if (csr_wr_en) begin
         case (csr_index)
            pdh_pkg::CSR_RADIAL_BINS:   radial_bins_ff   <= csr_wdata[pdh_pkg::BINS_W-1:0];
            pdh_pkg::CSR_INV_BIN_WIDTH: inv_bin_width_ff <= csr_wdata[pdh_pkg::INV_W-1:0];
            pdh_pkg::CSR_PAIR_SET_MAP:  pair_set_map_ff  <= csr_wdata[pdh_pkg::MAP_W-1:0];
            pdh_pkg::CSR_SPECIAL_KEEP:  special_keep_ff  <= csr_wdata[pdh_pkg::KEEP_W-1:0];
            pdh_pkg::CSR_REV_ALWAYS:    rev_always_ff    <= csr_wdata[0];
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Histogram memory: one row per bin, one 32-bit counter per set
   // -------------------------------------------------------------------------
   logic [ROW_W-1:0] hist_mem [MAX_BINS];
   logic [ROW_W-1:0] rd_data_ff;
   logic             mem_rd_en;
   logic             mem_wr_en;
   logic [BIN_W-1:0] rd_addr;
   logic [BIN_W-1:0] wr_addr;
   logic [ROW_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   // -------------------------------------------------------------------------
   // Sequencer and datapath registers
   // -------------------------------------------------------------------------
   pdh_pkg::pdh_state_type state_ff, state_in;

   logic                           clr_resp_ff, clr_resp_in;
   logic [BIN_W-1:0]               clr_cnt_ff, clr_cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pdh_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]             rsp_count_ff, rsp_count_in;
   logic [pdh_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [COUNT_W-1:0]             res_count_ff, res_count_in;
   logic [BIN_W-1:0]               addr_ff, addr_in;
   logic [pdh_pkg::SET_SEL_W-1:0]  set_ff, set_in;
   logic [COORD_BITS-1:0]          mag_x_ff, mag_x_in;
   logic [COORD_BITS-1:0]          mag_y_ff, mag_y_in;
   logic [COORD_BITS-1:0]          mag_z_ff, mag_z_in;
   logic [HIST_SETS-1:0]           fwd_ff, fwd_in;
   logic [HIST_SETS-1:0]           rev_ff, rev_in;
   logic [1:0]                     sq_cnt_ff, sq_cnt_in;
   logic [SQ_W-1:0]                sq_ff, sq_in;
   logic [SUM_W-1:0]               acc_ff, acc_in;
   logic [REM_W-1:0]               rem_ff, rem_in;
   logic [ROOT_W-1:0]              root_ff, root_in;
   logic [ROOT_CNT_W-1:0]          root_cnt_ff, root_cnt_in;
   logic [PROD_W-1:0]              scaled_ff, scaled_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdh_pkg::ST_CLEAR;   // clearing pass after reset
         clr_resp_ff  <= 1'b0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         sq_cnt_ff    <= '0;
         root_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_resp_ff  <= clr_resp_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         sq_cnt_ff    <= sq_cnt_in;
         root_cnt_ff  <= root_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      addr_ff       <= addr_in;
      set_ff        <= set_in;
      mag_x_ff      <= mag_x_in;
      mag_y_ff      <= mag_y_in;
      mag_z_ff      <= mag_z_in;
      fwd_ff        <= fwd_in;
      rev_ff        <= rev_in;
      sq_ff         <= sq_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      scaled_ff     <= scaled_in;
   end

   // -------------------------------------------------------------------------
   // Request decode: filter and set masks, worked out at acceptance
   // -------------------------------------------------------------------------
   logic [3:0]                 fwd_pair;
   logic [3:0]                 rev_pair;
   logic [pdh_pkg::NIBBLE_W-1:0] fwd_nib;
   logic [pdh_pkg::NIBBLE_W-1:0] rev_nib;
   logic                       typed;
   logic                       keep_class;
   logic                       filtered;
   logic                       do_rev;
   logic [HIST_SETS-1:0]       fwd_sets;
   logic [HIST_SETS-1:0]       rev_sets;
   logic                       read_in_range;
   logic [BIN_EXT_W-1:0]       read_bin_ext;
   logic [COORD_BITS-1:0]      abs_dx, abs_dy, abs_dz;

   assign fwd_pair   = {req_first_type, req_second_type};
   assign rev_pair   = {req_second_type, req_first_type};
   assign fwd_nib    = pair_set_map_ff[{fwd_pair, 2'b00} +: pdh_pkg::NIBBLE_W];
   assign rev_nib    = pair_set_map_ff[{rev_pair, 2'b00} +: pdh_pkg::NIBBLE_W];
   assign typed      = (32'(req_first_type) < ATOM_TYPES) && (32'(req_second_type) < ATOM_TYPES);
   assign keep_class = special_keep_ff[req_special_class];
   // reverse gating does not bear on the filter: an empty pair is one whose
   // forward and reverse nibbles are both clear
   assign filtered   = !keep_class || !req_second_in_group || !typed ||
                       ((fwd_nib == '0) && (rev_nib == '0));
   assign do_rev     = rev_always_ff || req_second_is_local;

   always_comb begin
      for (int s = 0; s < HIST_SETS; s++) begin
         fwd_sets[s] = (s < pdh_pkg::NIBBLE_W) && fwd_nib[2'(s)];
         rev_sets[s] = (s < pdh_pkg::NIBBLE_W) && do_rev && rev_nib[2'(s)];
      end
   end

   assign read_bin_ext  = BIN_EXT_W'(req_bin_index);
   assign read_in_range = (32'(req_set_index) < HIST_SETS) &&
                          (32'(req_bin_index) < MAX_BINS);

   // magnitudes fit COORD_BITS unsigned, the most negative value included
   assign abs_dx = req_dx[COORD_BITS-1] ? (~req_dx + 1'b1) : req_dx;
   assign abs_dy = req_dy[COORD_BITS-1] ? (~req_dy + 1'b1) : req_dy;
   assign abs_dz = req_dz[COORD_BITS-1] ? (~req_dz + 1'b1) : req_dz;

   // -------------------------------------------------------------------------
   // Datapath helpers
   // -------------------------------------------------------------------------
   logic [COORD_BITS-1:0] sq_operand;
   logic [REM_W+1:0]      rem_shifted;
   logic [REM_W+1:0]      root_trial;
   logic                  root_fits;
   logic [PROD_W-1:0]     bin_full;
   logic                  beyond;
   logic [COUNT_W-1:0]    picked_count;
   logic [ROW_W-1:0]      bumped_row;

   always_comb begin
      case (sq_cnt_ff)
         2'd0:    sq_operand = mag_x_ff;
         2'd1:    sq_operand = mag_y_ff;
         default: sq_operand = mag_z_ff;
      endcase
   end

   // restoring square root: bring down two bits, try (root << 2) | 1
   assign rem_shifted = {rem_ff, acc_ff[SUM_W-1 -: 2]};
   assign root_trial  = (REM_W + 2)'({root_ff, 2'b01});
   assign root_fits   = rem_shifted >= root_trial;

   assign bin_full = scaled_ff >> SHIFT;
   // bins in use are min(radial_bins, MAX_BINS)
   assign beyond   = (bin_full >= PROD_W'(radial_bins_ff)) || (bin_full >= PROD_W'(MAX_BINS));

   always_comb begin
      picked_count = '0;
      for (int s = 0; s < HIST_SETS; s++) begin
         if (32'(set_ff) == s) begin
            picked_count = rd_data_ff[s*COUNT_W +: COUNT_W];
         end
      end
   end

   // add one count per direction, saturate at all ones
   always_comb begin
      logic [COUNT_W:0] sum;
      for (int s = 0; s < HIST_SETS; s++) begin
         sum = (COUNT_W + 1)'(rd_data_ff[s*COUNT_W +: COUNT_W]) +
               (COUNT_W + 1)'(fwd_ff[s]) + (COUNT_W + 1)'(rev_ff[s]);
         bumped_row[s*COUNT_W +: COUNT_W] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
      end
   end

   // -------------------------------------------------------------------------
   // Next state and outputs
   // -------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      clr_resp_in   = clr_resp_ff;
      clr_cnt_in    = clr_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      addr_in       = addr_ff;
      set_in        = set_ff;
      mag_x_in      = mag_x_ff;
      mag_y_in      = mag_y_ff;
      mag_z_in      = mag_z_ff;
      fwd_in        = fwd_ff;
      rev_in        = rev_ff;
      sq_cnt_in     = sq_cnt_ff;
      sq_in         = sq_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      root_cnt_in   = root_cnt_ff;
      scaled_in     = scaled_ff;
      req_ready     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      rd_addr       = addr_ff;
      wr_addr       = addr_ff;
      wr_data       = bumped_row;

      // drop the response once taken; a delivery below may refill it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         pdh_pkg::ST_CLEAR: begin
            // zero one row per cycle
            mem_wr_en  = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_BIN) begin
               clr_cnt_in = '0;
               if (clr_resp_ff) begin
                  clr_resp_in   = 1'b0;
                  res_status_in = pdh_pkg::STATUS_DONE;
                  res_count_in  = '0;
                  state_in      = pdh_pkg::ST_DELIVER;
               end else begin
                  state_in = pdh_pkg::ST_IDLE;
               end
            end
         end

         pdh_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_count_in = '0;
               case (req_op)
                  pdh_pkg::OP_CLEAR: begin
                     clr_resp_in = 1'b1;
                     clr_cnt_in  = '0;
                     state_in    = pdh_pkg::ST_CLEAR;
                  end
                  pdh_pkg::OP_READ: begin
                     addr_in = read_bin_ext[BIN_W-1:0];
                     set_in  = req_set_index;
                     if (read_in_range) begin
                        state_in = pdh_pkg::ST_FETCH;
                     end else begin
                        res_status_in = pdh_pkg::STATUS_DONE;
                        state_in      = pdh_pkg::ST_DELIVER;
                     end
                  end
                  pdh_pkg::OP_TALLY: begin
                     if (filtered) begin
                        res_status_in = pdh_pkg::STATUS_FILTERED;
                        state_in      = pdh_pkg::ST_DELIVER;
                     end else begin
                        mag_x_in  = abs_dx;
                        mag_y_in  = abs_dy;
                        mag_z_in  = abs_dz;
                        fwd_in    = fwd_sets;
                        rev_in    = rev_sets;
                        sq_cnt_in = '0;
                        acc_in    = '0;
                        state_in  = pdh_pkg::ST_SQUARE;
                     end
                  end
                  default: begin
                     // unused op: answer and change nothing
                     res_status_in = pdh_pkg::STATUS_DONE;
                     state_in      = pdh_pkg::ST_DELIVER;
                  end
               endcase
            end
         end

         pdh_pkg::ST_FETCH: begin
            mem_rd_en = 1'b1;
            rd_addr   = addr_ff;
            state_in  = pdh_pkg::ST_PICK;
         end

         pdh_pkg::ST_PICK: begin
            res_status_in = pdh_pkg::STATUS_DONE;
            res_count_in  = picked_count;
            state_in      = pdh_pkg::ST_DELIVER;
         end

         pdh_pkg::ST_SQUARE: begin
            // square one axis per cycle, accumulate the previous square
            if (sq_cnt_ff != 2'd3) begin
               sq_in = SQ_W'(sq_operand) * SQ_W'(sq_operand);
            end
            if (sq_cnt_ff != 2'd0) begin
               acc_in = acc_ff + SUM_W'(sq_ff);
            end
            sq_cnt_in = sq_cnt_ff + 1'b1;
            if (sq_cnt_ff == 2'd3) begin
               rem_in      = '0;
               root_in     = '0;
               root_cnt_in = '0;
               state_in    = pdh_pkg::ST_ROOT;
            end
         end

         pdh_pkg::ST_ROOT: begin
            // one root bit per cycle, most significant first
            acc_in      = acc_ff << 2;
            root_cnt_in = root_cnt_ff + 1'b1;
            if (root_fits) begin
               rem_in  = REM_W'(rem_shifted - root_trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = REM_W'(rem_shifted);
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            if (root_cnt_ff == ROOT_LAST) begin
               state_in = pdh_pkg::ST_SCALE;
            end
         end

         pdh_pkg::ST_SCALE: begin
            scaled_in = PROD_W'(root_ff) * PROD_W'(inv_bin_width_ff);
            state_in  = pdh_pkg::ST_CHECK;
         end

         pdh_pkg::ST_CHECK: begin
            if (beyond) begin
               res_status_in = pdh_pkg::STATUS_BEYOND;
               state_in      = pdh_pkg::ST_DELIVER;
            end else begin
               mem_rd_en = 1'b1;
               rd_addr   = scaled_ff[SHIFT +: BIN_W];
               addr_in   = scaled_ff[SHIFT +: BIN_W];
               state_in  = pdh_pkg::ST_UPDATE;
            end
         end

         pdh_pkg::ST_UPDATE: begin
            // write back the bumped row; the read finished last cycle
            mem_wr_en     = 1'b1;
            wr_addr       = addr_ff;
            wr_data       = bumped_row;
            res_status_in = pdh_pkg::STATUS_TALLIED;
            state_in      = pdh_pkg::ST_DELIVER;
         end

         pdh_pkg::ST_DELIVER: begin
            // hold the result until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = res_count_ff;
               state_in      = pdh_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pdh_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_rd_en && mem_wr_en))
      else $error("histogram memory read and write in the same cycle");

   a_update_follows_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdh_pkg::ST_UPDATE) |-> ($past(state_ff) == pdh_pkg::ST_CHECK))
      else $error("row write-back without a preceding read");

   a_count_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != pdh_pkg::STATUS_DONE)) |-> (rsp_count_ff == '0))
      else $error("nonzero count on a tally response");

   a_no_request_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdh_pkg::ST_CLEAR) |-> !req_ready)
      else $error("request taken during the clearing pass");

   a_root_to_scale: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdh_pkg::ST_SCALE) |-> ($past(root_cnt_ff) == ROOT_LAST))
      else $error("root iteration ended early");

endmodule
